@@ rtl/fcpa_pkg.sv @@
// Shared types, codes and constants of the fixed chunk pool allocator.
package fcpa_pkg;

   localparam int MAX_CHUNKS_DEFAULT = 256;
   localparam int NODE_BYTES         = 8;

   localparam int OP_W       = 2;
   localparam int ADDR_W     = 32;
   localparam int LEN_W      = 21;
   localparam int CSIZE_W    = 16;
   localparam int ALIGN_W    = 13;
   localparam int EFF_W      = 17;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [ADDR_W-1:0]  BASE_RESET  = '0;
   localparam logic [LEN_W-1:0]   LEN_RESET   = LEN_W'(1024);
   localparam logic [CSIZE_W-1:0] CSIZE_RESET = CSIZE_W'(64);
   localparam logic [ALIGN_W-1:0] ALIGN_RESET = ALIGN_W'(8);

   typedef enum logic [OP_W-1:0] {
      OP_INIT  = 2'd0,
      OP_ALLOC = 2'd1,
      OP_FREE  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_EMPTY      = 3'd1,
      ST_BAD_FREE   = 3'd2,
      ST_NULL       = 3'd3,
      ST_BAD_CONFIG = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE   = 2'd0,
      CSR_LENGTH = 2'd1,
      CSR_CHUNK  = 2'd2,
      CSR_ALIGN  = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_INIT_ALIGN,
      S_INIT_TRIM,
      S_INIT_CHECK,
      S_INIT_FILL,
      S_ALLOC_READ,
      S_ALLOC_POP,
      S_FREE_CHECK,
      S_FREE_DIV,
      S_FREE_PUSH,
      S_DONE
   } fsm_state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_CAPTURE,
      CMD_INIT_ALIGN,
      CMD_INIT_TRIM,
      CMD_INIT_CHECK,
      CMD_FILL,
      CMD_ALLOC_READ,
      CMD_ALLOC_POP,
      CMD_SET_EMPTY,
      CMD_SET_NULL,
      CMD_FREE_CHECK,
      CMD_DIV_STEP,
      CMD_FREE_PUSH,
      CMD_EMIT
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type cmd;
      logic       req_ready;
   } ctl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   is_null;
      logic   head_nil;
      logic   fill_done;
      logic   free_bad;
      logic   div_done;
      logic   out_free;
   } dp_status_type;

endpackage

@@ rtl/fcpa_req_if.sv @@
// Request channel: operation word with valid/ready handshake.
interface fcpa_req_if
   import fcpa_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [ADDR_W-1:0] address;
   logic              is_null;

   modport source (output valid, op, address, is_null, input ready);
   modport sink   (input valid, op, address, is_null, output ready);
endinterface

@@ rtl/fcpa_rsp_if.sv @@
// Response channel: chunk address and status word with valid/ready handshake.
interface fcpa_rsp_if
   import fcpa_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   chunk_address;
   logic [STATUS_W-1:0] status;

   modport source (output valid, chunk_address, status, input ready);
   modport sink   (input valid, chunk_address, status, output ready);
endinterface

@@ rtl/fcpa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fcpa_ram
   import fcpa_pkg::*;
#(
   parameter int WIDTH = 9,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/fcpa_ctrl.sv @@
// Sequencing state machine: walks each operation through the datapath steps.
module fcpa_ctrl
   import fcpa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  dp_status_type status,
   output ctl_cmd_type   ctl
);

   fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            case (status.op)
               OP_INIT:  state_in = S_INIT_ALIGN;
               OP_ALLOC: state_in = status.head_nil ? S_DONE : S_ALLOC_READ;
               OP_FREE:  state_in = status.is_null ? S_DONE : S_FREE_CHECK;
               default:  state_in = S_DONE;
            endcase
         end
         S_INIT_ALIGN: state_in = S_INIT_TRIM;
         S_INIT_TRIM:  state_in = S_INIT_CHECK;
         S_INIT_CHECK: state_in = S_INIT_FILL;
         S_INIT_FILL: begin
            if (status.fill_done) state_in = S_DONE;
         end
         S_ALLOC_READ: state_in = S_ALLOC_POP;
         S_ALLOC_POP:  state_in = S_DONE;
         S_FREE_CHECK: state_in = S_FREE_DIV;
         S_FREE_DIV: begin
            if (status.free_bad) begin
               state_in = S_DONE;
            end else if (status.div_done) begin
               state_in = S_FREE_PUSH;
            end
         end
         S_FREE_PUSH: state_in = S_DONE;
         S_DONE: begin
            if (status.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl.req_ready = 1'b0;
      ctl.cmd       = CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            ctl.req_ready = 1'b1;
            if (req_valid) ctl.cmd = CMD_CAPTURE;
         end
         S_DECODE: begin
            if (status.op == OP_ALLOC && status.head_nil) begin
               ctl.cmd = CMD_SET_EMPTY;
            end else if (status.op == OP_FREE && status.is_null) begin
               ctl.cmd = CMD_SET_NULL;
            end
         end
         S_INIT_ALIGN: ctl.cmd = CMD_INIT_ALIGN;
         S_INIT_TRIM:  ctl.cmd = CMD_INIT_TRIM;
         S_INIT_CHECK: ctl.cmd = CMD_INIT_CHECK;
         S_INIT_FILL: begin
            if (!status.fill_done) ctl.cmd = CMD_FILL;
         end
         S_ALLOC_READ: ctl.cmd = CMD_ALLOC_READ;
         S_ALLOC_POP:  ctl.cmd = CMD_ALLOC_POP;
         S_FREE_CHECK: ctl.cmd = CMD_FREE_CHECK;
         S_FREE_DIV: begin
            if (!status.free_bad && !status.div_done) ctl.cmd = CMD_DIV_STEP;
         end
         S_FREE_PUSH: ctl.cmd = CMD_FREE_PUSH;
         S_DONE: begin
            if (status.out_free) ctl.cmd = CMD_EMIT;
         end
         default: ctl.cmd = CMD_NONE;
      endcase
   end

   // one word in flight: no second accept until the result is handed off
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && ctl.req_ready) |=> !ctl.req_ready)
      else $error("request accepted while an item is in flight");

   a_emit_to_idle: assert property (@(posedge clock) disable iff (reset)
      (ctl.cmd == CMD_EMIT) |=> (state_ff == S_IDLE))
      else $error("result emitted without returning to idle");

endmodule

@@ rtl/fcpa_dp.sv @@
// Datapath: config registers, free-list head, link RAM, divider and result regs.
module fcpa_dp
   import fcpa_pkg::*;
#(
   parameter int MAX_CHUNKS = MAX_CHUNKS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic [OP_W-1:0]       req_op,
   input  logic [ADDR_W-1:0]     req_address,
   input  logic                  req_is_null,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ADDR_W-1:0]     rsp_chunk_address,
   output logic [STATUS_W-1:0]   rsp_status,
   input  ctl_cmd_type           ctl,
   output dp_status_type         status
);

   localparam int AW   = $clog2(MAX_CHUNKS);
   localparam int IW   = $clog2(MAX_CHUNKS + 1);
   localparam int CW   = $clog2(AW + 1);
   localparam int DIVW = EFF_W + AW - 1;
   localparam int CMPW = (DIVW > LEN_W) ? DIVW : LEN_W;
   localparam int PW   = AW + EFF_W;
   localparam logic [IW-1:0] NIL = IW'(MAX_CHUNKS);

   // configuration
   logic [ADDR_W-1:0]  base_ff,  base_in;
   logic [LEN_W-1:0]   len_ff,   len_in;
   logic [CSIZE_W-1:0] csize_ff, csize_in;
   logic [ALIGN_W-1:0] align_ff, align_in;

   // pool state
   logic [IW-1:0]     head_ff,  head_in;
   logic [IW-1:0]     total_ff, total_in;
   logic [ADDR_W-1:0] pool_start_ff, pool_start_in;
   logic [EFF_W-1:0]  pool_eff_ff, pool_eff_in;
   logic [LEN_W-1:0]  span_ff, span_in;

   // init work
   logic [ADDR_W:0]   wk_start_ff, wk_start_in;
   logic [EFF_W-1:0]  wk_eff_ff, wk_eff_in;
   logic [LEN_W-1:0]  wk_usable_ff, wk_usable_in;
   logic              align_ok_ff, align_ok_in;
   logic              trim_bad_ff, trim_bad_in;
   logic              init_bad_ff, init_bad_in;
   logic [LEN_W-1:0]  remain_ff, remain_in;
   logic [IW-1:0]     fill_idx_ff, fill_idx_in;

   // alloc / free work
   logic [PW-1:0]     prod_ff, prod_in;
   logic              free_bad_ff, free_bad_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [DIVW-1:0]   div_ff, div_in;
   logic [AW-1:0]     quot_ff, quot_in;
   logic [CW-1:0]     div_cnt_ff, div_cnt_in;

   // captured request and result
   op_type            op_ff, op_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              null_ff, null_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   status_type        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   status_type        rsp_status_ff, rsp_status_in;

   // link RAM
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [IW-1:0] ram_wr_data;
   logic          ram_rd_en;
   logic [IW-1:0] ram_rd_data;

   // combinational helpers
   logic [ALIGN_W-1:0] am1;
   logic [ADDR_W:0]    trim;
   logic [ADDR_W+1:0]  pool_end;
   logic               cfg_bad;
   logic [ADDR_W:0]    off;
   logic               out_free;
   logic               div_ge;

   fcpa_ram #(
      .WIDTH (IW),
      .DEPTH (MAX_CHUNKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      am1      = ALIGN_W'(align_ff - 1'b1);
      trim     = wk_start_ff - {1'b0, base_ff};
      pool_end = (ADDR_W+2)'(wk_start_ff) + (ADDR_W+2)'(wk_usable_ff);
      cfg_bad  = !align_ok_ff || trim_bad_ff
                 || (wk_eff_ff < EFF_W'(NODE_BYTES))
                 || (wk_usable_ff < LEN_W'(wk_eff_ff))
                 || wk_start_ff[ADDR_W]
                 || (pool_end > (ADDR_W+2)'(1) << ADDR_W);
      off      = {1'b0, addr_ff} - {1'b0, pool_start_ff};
      out_free = !rsp_valid_ff || rsp_ready;
      div_ge   = CMPW'(rem_ff) >= CMPW'(div_ff);
   end

   always_comb begin
      base_in       = base_ff;
      len_in        = len_ff;
      csize_in      = csize_ff;
      align_in      = align_ff;
      head_in       = head_ff;
      total_in      = total_ff;
      pool_start_in = pool_start_ff;
      pool_eff_in   = pool_eff_ff;
      span_in       = span_ff;
      wk_start_in   = wk_start_ff;
      wk_eff_in     = wk_eff_ff;
      wk_usable_in  = wk_usable_ff;
      align_ok_in   = align_ok_ff;
      trim_bad_in   = trim_bad_ff;
      init_bad_in   = init_bad_ff;
      remain_in     = remain_ff;
      fill_idx_in   = fill_idx_ff;
      prod_in       = prod_ff;
      free_bad_in   = free_bad_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      quot_in       = quot_ff;
      div_cnt_in    = div_cnt_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      null_in       = null_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = fill_idx_ff[AW-1:0];
      ram_wr_data   = (fill_idx_ff == '0) ? NIL : IW'(fill_idx_ff - 1'b1);
      ram_rd_en     = 1'b0;

      if (csr_write_en) begin
         case (csr_idx_type'(csr_index))
            CSR_BASE:   base_in  = csr_write_data[ADDR_W-1:0];
            CSR_LENGTH: len_in   = csr_write_data[LEN_W-1:0];
            CSR_CHUNK:  csize_in = csr_write_data[CSIZE_W-1:0];
            CSR_ALIGN:  align_in = csr_write_data[ALIGN_W-1:0];
            default:    ;
         endcase
      end

      case (ctl.cmd)
         CMD_CAPTURE: begin
            op_in         = op_type'(req_op);
            addr_in       = req_address;
            null_in       = req_is_null;
            res_addr_in   = '0;
            res_status_in = ST_OK;
         end
         CMD_INIT_ALIGN: begin
            // empty the pool, round base and chunk size up to the alignment
            head_in       = NIL;
            total_in      = '0;
            pool_start_in = '0;
            pool_eff_in   = '0;
            span_in       = '0;
            align_ok_in   = (align_ff != '0) && ((align_ff & am1) == '0);
            wk_start_in   = ({1'b0, base_ff} + (ADDR_W+1)'(am1))
                            & ~((ADDR_W+1)'(am1));
            wk_eff_in     = ({1'b0, csize_ff} + EFF_W'(am1)) & ~(EFF_W'(am1));
         end
         CMD_INIT_TRIM: begin
            trim_bad_in  = trim > (ADDR_W+1)'(len_ff);
            wk_usable_in = LEN_W'((ADDR_W+1)'(len_ff) - trim);
         end
         CMD_INIT_CHECK: begin
            init_bad_in   = cfg_bad;
            res_status_in = cfg_bad ? ST_BAD_CONFIG : ST_OK;
            fill_idx_in   = '0;
            remain_in     = wk_usable_ff;
            if (!cfg_bad) begin
               pool_start_in = wk_start_ff[ADDR_W-1:0];
               pool_eff_in   = wk_eff_ff;
            end
         end
         CMD_FILL: begin
            // chunk i links to chunk i-1, chunk 0 ends the list
            ram_wr_en   = 1'b1;
            head_in     = fill_idx_ff;
            total_in    = IW'(fill_idx_ff + 1'b1);
            fill_idx_in = IW'(fill_idx_ff + 1'b1);
            span_in     = LEN_W'(span_ff + LEN_W'(pool_eff_ff));
            remain_in   = LEN_W'(remain_ff - LEN_W'(pool_eff_ff));
         end
         CMD_ALLOC_READ: begin
            ram_rd_en = 1'b1;
            prod_in   = PW'(head_ff[AW-1:0]) * PW'(pool_eff_ff);
         end
         CMD_ALLOC_POP: begin
            head_in     = ram_rd_data;
            res_addr_in = ADDR_W'(pool_start_ff + ADDR_W'(prod_ff));
         end
         CMD_SET_EMPTY: res_status_in = ST_EMPTY;
         CMD_SET_NULL:  res_status_in = ST_NULL;
         CMD_FREE_CHECK: begin
            free_bad_in = (total_ff == '0) || (addr_ff < pool_start_ff)
                          || (off >= (ADDR_W+1)'(span_ff));
            if ((total_ff == '0) || (addr_ff < pool_start_ff)
                || (off >= (ADDR_W+1)'(span_ff))) begin
               res_status_in = ST_BAD_FREE;
            end
            rem_in     = off[LEN_W-1:0];
            div_in     = DIVW'(pool_eff_ff) << (AW - 1);
            quot_in    = '0;
            div_cnt_in = CW'(AW);
         end
         CMD_DIV_STEP: begin
            // restoring division, one quotient bit per cycle, MSB first
            if (div_ge) rem_in = LEN_W'(CMPW'(rem_ff) - CMPW'(div_ff));
            quot_in    = AW'({quot_ff, div_ge});
            div_in     = div_ff >> 1;
            div_cnt_in = CW'(div_cnt_ff - 1'b1);
         end
         CMD_FREE_PUSH: begin
            if (rem_ff != '0) begin
               res_status_in = ST_BAD_FREE;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = quot_ff;
               ram_wr_data = head_ff;
               head_in     = IW'(quot_ff);
            end
         end
         CMD_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_addr_in   = res_addr_ff;
            rsp_status_in = res_status_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= BASE_RESET;
         len_ff        <= LEN_RESET;
         csize_ff      <= CSIZE_RESET;
         align_ff      <= ALIGN_RESET;
         head_ff       <= NIL;
         total_ff      <= '0;
         pool_start_ff <= '0;
         pool_eff_ff   <= '0;
         span_ff       <= '0;
         init_bad_ff   <= 1'b0;
         free_bad_ff   <= 1'b0;
         fill_idx_ff   <= '0;
         div_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         base_ff       <= base_in;
         len_ff        <= len_in;
         csize_ff      <= csize_in;
         align_ff      <= align_in;
         head_ff       <= head_in;
         total_ff      <= total_in;
         pool_start_ff <= pool_start_in;
         pool_eff_ff   <= pool_eff_in;
         span_ff       <= span_in;
         init_bad_ff   <= init_bad_in;
         free_bad_ff   <= free_bad_in;
         fill_idx_ff   <= fill_idx_in;
         div_cnt_ff    <= div_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wk_start_ff   <= wk_start_in;
      wk_eff_ff     <= wk_eff_in;
      wk_usable_ff  <= wk_usable_in;
      align_ok_ff   <= align_ok_in;
      trim_bad_ff   <= trim_bad_in;
      remain_ff     <= remain_in;
      prod_ff       <= prod_in;
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      quot_ff       <= quot_in;
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      null_ff       <= null_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      status.op        = op_ff;
      status.is_null   = null_ff;
      status.head_nil  = head_ff >= NIL;
      status.fill_done = init_bad_ff || (remain_ff < LEN_W'(pool_eff_ff))
                         || (fill_idx_ff == NIL);
      status.free_bad  = free_bad_ff;
      status.div_done  = div_cnt_ff == '0;
      status.out_free  = out_free;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chunk_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;

   a_head_in_pool: assert property (@(posedge clock) disable iff (reset)
      (head_ff == NIL) || (head_ff < total_ff))
      else $error("free-list head points outside the pool");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= NIL)
      else $error("chunk count above capacity");

   a_push_after_div: assert property (@(posedge clock) disable iff (reset)
      (ctl.cmd == CMD_FREE_PUSH) |-> (div_cnt_ff == '0))
      else $error("free pushed before the index division finished");

endmodule

@@ rtl/fixed_chunk_pool_allocator_top.sv @@
// Top level of the fixed chunk pool allocator: controller, datapath and ports.
//
// Usage: a request word on req_chan carries op (init, allocate, free), the
// address to free and a null flag; every request yields exactly one response
// word on rsp_chan with the chunk address (zero unless an allocate succeeds)
// and a status code. Region base, length, chunk size and alignment are set
// through the csr_ write port while no request is in flight.
// One request is worked on at a time; the next is taken once the result is
// parked in the response register. Steps from accept to the next accept:
//   allocate: link RAM read with index multiply, then address add
//   free: bounds check, divider (one quotient bit per cycle), then link push
//   free below the pool, past its end or with no pool: bounds check (divider skipped)
//   init: align, trim, check, then one link RAM write per chunk
//   null free, empty pool, unused op: decode only
// Reset empties the pool (head null, no chunks) and restores the register
// defaults; the link RAM keeps whatever it held and is rewritten by init.
// When rsp_chan stalls, the result waits in the response register and the
// controller holds in its done state until the word is taken.
module fixed_chunk_pool_allocator_top
   import fcpa_pkg::*;
#(
   parameter int MAX_CHUNKS = MAX_CHUNKS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   fcpa_req_if.sink              req_chan,
   fcpa_rsp_if.source            rsp_chan,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   ctl_cmd_type   ctl;
   dp_status_type dp_status;

   // sequencing
   fcpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .status    (dp_status),
      .ctl       (ctl)
   );

   assign req_chan.ready = ctl.req_ready;

   // storage, arithmetic and the response register
   fcpa_dp #(
      .MAX_CHUNKS (MAX_CHUNKS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_op            (req_chan.op),
      .req_address       (req_chan.address),
      .req_is_null       (req_chan.is_null),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_chunk_address (rsp_chan.chunk_address),
      .rsp_status        (rsp_chan.status),
      .ctl               (ctl),
      .status            (dp_status)
   );

endmodule

@@ test/tb_fixed_chunk_pool_allocator_top.sv @@
// Self-checking bench for the fixed chunk pool allocator: directed table, then random phases.
module tb_fixed_chunk_pool_allocator_top;
   import fcpa_pkg::*;

   localparam int MAX_CHUNKS = MAX_CHUNKS_DEFAULT;
   localparam logic [8:0] NIL_LINK = 9'(MAX_CHUNKS);
   localparam int RANDOM_WORDS = 1300;
   localparam int CALM_TAIL = 150;
   localparam int HOLD_OFF_AT = 300;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int CYCLE_LIMIT = 600000;

   // One expected response word.
   typedef struct {
      logic [ADDR_W-1:0] chunk_address;
      status_type        status;
   } pool_answer_type;

   // One row of the directed table: either a register write or a request word.
   typedef struct {
      logic              is_csr;
      csr_idx_type       csr;
      logic [31:0]       word;
      op_type            op;
      logic              is_null;
      logic              typed;
      logic [ADDR_W-1:0] want_addr;
      status_type        want_status;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   fcpa_req_if req_chan ();
   fcpa_rsp_if rsp_chan ();

   fixed_chunk_pool_allocator_top #(.MAX_CHUNKS(MAX_CHUNKS)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // Bench copy of the registers.
   logic [ADDR_W-1:0]  cfg_base;
   logic [LEN_W-1:0]   cfg_len;
   logic [CSIZE_W-1:0] cfg_chunk;
   logic [ALIGN_W-1:0] cfg_align;

   // Bench copy of the free list and pool geometry.
   logic [8:0]        link_of [MAX_CHUNKS];
   logic [8:0]        head_idx;
   logic [8:0]        pool_chunks;
   logic [ADDR_W-1:0] pool_start;
   logic [EFF_W-1:0]  chunk_bytes;
   logic [LEN_W-1:0]  pool_usable;

   pool_answer_type answers_due[$];
   int unsigned mismatches = 0;
   int unsigned responses_seen = 0;
   int unsigned cycle_count = 0;
   logic        quiet_tail = 1'b0;
   logic        sender_calm = 1'b0;
   logic        receiver_calm = 1'b0;
   logic        held_once = 1'b0;

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      mismatches++;
   endtask

   // Work out the response of one request word and advance the bench copy of the pool.
   task automatic predict_word(input op_type op, input logic [ADDR_W-1:0] addr,
                               input logic nul, output pool_answer_type ans);
      logic [63:0] a;
      logic [63:0] start64;
      logic [63:0] trim;
      logic [63:0] room;
      logic [63:0] eff64;
      logic [63:0] cnt;
      logic [63:0] off;
      logic [63:0] span;
      logic [8:0]  idx;
      ans.chunk_address = '0;
      ans.status = ST_OK;
      case (op)
         OP_INIT: begin
            // Empty the pool first; a bad setting leaves it empty.
            head_idx = NIL_LINK;
            pool_chunks = '0;
            pool_start = '0;
            chunk_bytes = '0;
            pool_usable = '0;
            a = 64'(cfg_align);
            if (a == 0 || (a & (a - 1)) != 0) begin
               ans.status = ST_BAD_CONFIG;
            end else begin
               start64 = (64'(cfg_base) + a - 1) & ~(a - 1);
               trim = start64 - 64'(cfg_base);
               room = 64'(cfg_len) - trim;
               eff64 = (64'(cfg_chunk) + a - 1) & ~(a - 1);
               if (trim > 64'(cfg_len) || eff64 < NODE_BYTES || room < eff64 ||
                   start64 > 64'hFFFF_FFFF || start64 + room > 64'h1_0000_0000) begin
                  ans.status = ST_BAD_CONFIG;
               end else begin
                  cnt = room / eff64;
                  if (cnt > MAX_CHUNKS) cnt = MAX_CHUNKS;
                  // Push chunks in ascending order so the top one is handed out first.
                  for (int i = 0; i < cnt; i++) begin
                     link_of[i] = (i == 0) ? NIL_LINK : 9'(i - 1);
                  end
                  head_idx = 9'(cnt - 1);
                  pool_chunks = 9'(cnt);
                  pool_start = start64[ADDR_W-1:0];
                  chunk_bytes = eff64[EFF_W-1:0];
                  pool_usable = room[LEN_W-1:0];
               end
            end
         end
         OP_ALLOC: begin
            if (head_idx >= NIL_LINK) begin
               ans.status = ST_EMPTY;
            end else begin
               idx = head_idx;
               head_idx = link_of[idx];
               ans.chunk_address = 32'(64'(pool_start) + 64'(idx) * 64'(chunk_bytes));
            end
         end
         OP_FREE: begin
            if (nul) begin
               ans.status = ST_NULL;
            end else if (pool_chunks == 0 || chunk_bytes == 0 || addr < pool_start) begin
               ans.status = ST_BAD_FREE;
            end else begin
               off = 64'(addr) - 64'(pool_start);
               span = 64'(pool_chunks) * 64'(chunk_bytes);
               if (off >= span || off % chunk_bytes != 0) begin
                  ans.status = ST_BAD_FREE;
               end else begin
                  // A double free is pushed again, just like any other chunk.
                  idx = 9'(off / chunk_bytes);
                  link_of[idx] = head_idx;
                  head_idx = idx;
               end
            end
         end
         default: ;
      endcase
   endtask

   // Offer one request word; starts and ends at a falling edge.
   task automatic offer_word(input op_type op, input logic [ADDR_W-1:0] addr, input logic nul,
                             input logic typed, input logic [ADDR_W-1:0] want_addr,
                             input status_type want_status);
      pool_answer_type ans;
      if (!quiet_tail && !sender_calm && $urandom_range(0, 3) == 0) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_chan.op = op;
      req_chan.address = addr;
      req_chan.is_null = nul;
      req_chan.valid = 1'b1;
      forever begin
         @(posedge clock);
         if (req_chan.ready) break;
      end
      predict_word(op, addr, nul, ans);
      if (typed) begin
         ans.chunk_address = want_addr;
         ans.status = want_status;
      end
      answers_due.push_back(ans);
      @(negedge clock);
   endtask

   // Write one register; only called while the block is idle.
   task automatic write_register(input csr_idx_type idx, input logic [31:0] data);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      case (idx)
         CSR_BASE:   cfg_base = data;
         CSR_LENGTH: cfg_len = data[LEN_W-1:0];
         CSR_CHUNK:  cfg_chunk = data[CSIZE_W-1:0];
         CSR_ALIGN:  cfg_align = data[ALIGN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   // Drop valid and wait until every expected word is back and the controller is idle.
   task automatic settle_pool;
      req_chan.valid = 1'b0;
      while (answers_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic plan_row_type ask(input op_type op, input logic [31:0] addr,
                                        input logic nul, input logic typed,
                                        input logic [31:0] want_addr,
                                        input status_type want_status);
      plan_row_type r;
      r.is_csr = 1'b0;
      r.csr = CSR_BASE;
      r.word = addr;
      r.op = op;
      r.is_null = nul;
      r.typed = typed;
      r.want_addr = want_addr;
      r.want_status = want_status;
      return r;
   endfunction

   function automatic plan_row_type poke(input csr_idx_type idx, input logic [31:0] data);
      plan_row_type r;
      r = ask(OP_NOP, data, 1'b0, 1'b0, '0, ST_OK);
      r.is_csr = 1'b1;
      r.csr = idx;
      return r;
   endfunction

   // Cycle counter: end the run if it hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Response checker: compare every accepted word against the oldest expectation.
   always @(posedge clock) begin
      pool_answer_type due;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         responses_seen++;
         if (answers_due.size() == 0) begin
            report_mismatch($sformatf("unexpected word addr=%h status=%0d",
                                      rsp_chan.chunk_address, rsp_chan.status));
         end else begin
            due = answers_due.pop_front();
            if (rsp_chan.chunk_address !== due.chunk_address)
               report_mismatch($sformatf("chunk_address %h, want %h",
                                         rsp_chan.chunk_address, due.chunk_address));
            if (rsp_chan.status !== due.status)
               report_mismatch($sformatf("status %0d, want %0d",
                                         rsp_chan.status, due.status));
         end
      end
   end

   // Response side: random stalls, calm stretches, and one long hold-off so the block
   // backs up and stalls its request channel.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_once && responses_seen >= HOLD_OFF_AT) begin
            held_once = 1'b1;
            rsp_chan.ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         if ($urandom_range(0, 63) == 0) receiver_calm = !receiver_calm;
         if (!quiet_tail && !receiver_calm && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready = 1'b0;
            repeat ($urandom_range(1, 5) - 1) @(negedge clock);
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   // Request side: reset, directed table, then random phases.
   initial begin
      plan_row_type      plan[$];
      int unsigned       counted;
      int unsigned       dice;
      op_type            pick_op;
      logic [ADDR_W-1:0] pick_addr;
      logic              pick_null;

      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = CSR_BASE;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.op = OP_NOP;
      req_chan.address = '0;
      req_chan.is_null = 1'b0;

      // Register defaults and an empty pool after reset.
      cfg_base = BASE_RESET;
      cfg_len = LEN_RESET;
      cfg_chunk = CSIZE_RESET;
      cfg_align = ALIGN_RESET;
      head_idx = NIL_LINK;
      pool_chunks = '0;
      pool_start = '0;
      chunk_bytes = '0;
      pool_usable = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty pool straight out of reset, free with no pool, null free, unused op.
      plan.push_back(ask(OP_ALLOC, 32'h0, 1'b0, 1'b1, 32'h0, ST_EMPTY));
      plan.push_back(ask(OP_FREE, 32'h0, 1'b0, 1'b1, 32'h0, ST_BAD_FREE));
      plan.push_back(ask(OP_FREE, 32'h40, 1'b1, 1'b1, 32'h0, ST_NULL));
      plan.push_back(ask(OP_NOP, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0, ST_OK));
      // Default region: 16 chunks of 64 bytes at zero, top chunk first.
      plan.push_back(ask(OP_INIT, 32'h0, 1'b0, 1'b1, 32'h0, ST_OK));
      plan.push_back(ask(OP_ALLOC, 32'h0, 1'b0, 1'b0, 32'h0, ST_OK));
      plan.push_back(ask(OP_ALLOC, 32'h0, 1'b0, 1'b0, 32'h0, ST_OK));
      plan.push_back(ask(OP_FREE, 32'd960, 1'b0, 1'b0, 32'h0, ST_OK));
      // Misaligned, one past the end, top of address space, null with a real address.
      plan.push_back(ask(OP_FREE, 32'd961, 1'b0, 1'b1, 32'h0, ST_BAD_FREE));
      plan.push_back(ask(OP_FREE, 32'd1024, 1'b0, 1'b1, 32'h0, ST_BAD_FREE));
      plan.push_back(ask(OP_FREE, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0, ST_BAD_FREE));
      plan.push_back(ask(OP_FREE, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0, ST_NULL));
      // Double free: the same chunk comes back twice.
      plan.push_back(ask(OP_FREE, 32'd960, 1'b0, 1'b0, 32'h0, ST_OK));
      plan.push_back(ask(OP_ALLOC, 32'h0, 1'b0, 1'b0, 32'h0, ST_OK));
      plan.push_back(ask(OP_ALLOC, 32'h0, 1'b0, 1'b0, 32'h0, ST_OK));
      // Alignment not a power of two, then zero: init empties the pool.
      plan.push_back(poke(CSR_ALIGN, 32'd3));
      plan.push_back(ask(OP_INIT, 32'h0, 1'b0, 1'b1, 32'h0, ST_BAD_CONFIG));
      plan.push_back(ask(OP_ALLOC, 32'h0, 1'b0, 1'b1, 32'h0, ST_EMPTY));
      plan.push_back(poke(CSR_ALIGN, 32'd0));
      plan.push_back(ask(OP_INIT, 32'h0, 1'b0, 1'b1, 32'h0, ST_BAD_CONFIG));
      // Alignment trim longer than the region.
      plan.push_back(poke(CSR_ALIGN, 32'd4096));
      plan.push_back(poke(CSR_BASE, 32'd1));
      plan.push_back(poke(CSR_LENGTH, 32'd100));
      plan.push_back(ask(OP_INIT, 32'h0, 1'b0, 1'b1, 32'h0, ST_BAD_CONFIG));
      // Region running past the top of the address space.
      plan.push_back(poke(CSR_ALIGN, 32'd8));
      plan.push_back(poke(CSR_BASE, 32'hFFFF_FF00));
      plan.push_back(poke(CSR_LENGTH, 32'd1024));
      plan.push_back(ask(OP_INIT, 32'h0, 1'b0, 1'b1, 32'h0, ST_BAD_CONFIG));
      // Chunk smaller than a list node.
      plan.push_back(poke(CSR_BASE, 32'h0));
      plan.push_back(poke(CSR_CHUNK, 32'd4));
      plan.push_back(poke(CSR_ALIGN, 32'd1));
      plan.push_back(ask(OP_INIT, 32'h0, 1'b0, 1'b1, 32'h0, ST_BAD_CONFIG));
      // A region of 0x10_0000 bytes with the smallest chunk: the count saturates, the tail is not pool.
      plan.push_back(poke(CSR_CHUNK, 32'd8));
      plan.push_back(poke(CSR_LENGTH, 32'h10_0000));
      plan.push_back(ask(OP_INIT, 32'h0, 1'b0, 1'b1, 32'h0, ST_OK));
      plan.push_back(ask(OP_ALLOC, 32'h0, 1'b0, 1'b0, 32'h0, ST_OK));
      plan.push_back(ask(OP_FREE, 32'd2048, 1'b0, 1'b1, 32'h0, ST_BAD_FREE));
      plan.push_back(ask(OP_FREE, 32'h0, 1'b0, 1'b0, 32'h0, ST_OK));

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            settle_pool();
            write_register(plan[i].csr, plan[i].word);
         end else begin
            offer_word(plan[i].op, plan[i].word, plan[i].is_null, plan[i].typed,
                       plan[i].want_addr, plan[i].want_status);
         end
      end

      // Random phases: new geometry, init, then mostly well-formed alloc/free traffic.
      counted = 0;
      while (counted < RANDOM_WORDS) begin
         settle_pool();
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
               0:       write_register(CSR_BASE, 32'h0);
               1:       write_register(CSR_BASE, 32'hFFFF_FFFF);
               2:       write_register(CSR_BASE, $urandom);
               3:       write_register(CSR_BASE, 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF));
               default: write_register(CSR_BASE, $urandom_range(0, 32'h10_0000));
            endcase
         end
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 6))
               0:       write_register(CSR_LENGTH, 32'h0);
               1:       write_register(CSR_LENGTH, 32'h10_0000);
               2:       write_register(CSR_LENGTH, 32'h1F_FFFF);
               3:       write_register(CSR_LENGTH, $urandom_range(0, 32'h1F_FFFF));
               default: write_register(CSR_LENGTH, $urandom_range(0, 4096));
            endcase
         end
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 6))
               0:       write_register(CSR_CHUNK, 32'h0);
               1:       write_register(CSR_CHUNK, 32'hFFFF);
               2:       write_register(CSR_CHUNK, $urandom_range(1, 7));
               default: write_register(CSR_CHUNK, $urandom_range(1, 300));
            endcase
         end
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
               0:       write_register(CSR_ALIGN, 32'h0);
               1:       write_register(CSR_ALIGN, $urandom_range(0, 13'h1FFF));
               2:       write_register(CSR_ALIGN, 32'd4096);
               default: write_register(CSR_ALIGN, 32'd1 << $urandom_range(0, 7));
            endcase
         end

         offer_word(OP_INIT, $urandom, 1'b0, 1'b0, '0, ST_OK);
         counted++;
         sender_calm = ($urandom_range(0, 3) == 0);

         repeat ($urandom_range(20, 80)) begin
            dice = $urandom_range(0, 99);
            pick_addr = $urandom;
            pick_null = 1'b0;
            pick_op = OP_FREE;
            if (dice < 45) begin
               pick_op = OP_ALLOC;
            end else if (dice < 83) begin
               // Free a chunk that belongs to the pool (maybe one already free).
               if (pool_chunks != 0)
                  pick_addr = pool_start + $urandom_range(0, pool_chunks - 1) * chunk_bytes;
            end else if (dice < 88) begin
               // Near miss: off the chunk boundary or just past the last chunk.
               pick_addr = pool_start + $urandom_range(0, pool_chunks) * chunk_bytes
                           + $urandom_range(0, 3);
            end else if (dice < 90) begin
               pick_addr = $urandom;
            end else if (dice < 94) begin
               pick_null = 1'b1;
            end else if (dice < 97) begin
               pick_op = OP_NOP;
            end else begin
               pick_op = OP_INIT;
            end
            offer_word(pick_op, pick_addr, pick_null, 1'b0, '0, ST_OK);
            counted++;
            if (counted >= RANDOM_WORDS - CALM_TAIL) quiet_tail = 1'b1;
         end
      end

      // Drain and let the controller go idle before judging.
      settle_pool();
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
